// File: hdl/udr_pkg.sv
// Package for the diagnostic responder: service codes, response codes,
// register indexes and the controller/datapath command and status types.
// No dependencies.
package udr_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SECURITY_LEVEL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_LEVEL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENGINE_TEMP_ID  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_ID    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_CAN_ID = 3'd4;

	localparam logic [7:0]  RST_SECURITY_LEVEL  = 8'd1;
	localparam logic [7:0]  RST_REQUIRED_LEVEL  = 8'd1;
	localparam logic [15:0] RST_ENGINE_TEMP_ID  = 16'hF001;
	localparam logic [15:0] RST_THRESHOLD_ID    = 16'hF002;
	localparam logic [10:0] RST_RESPONSE_CAN_ID = 11'h768;
	localparam logic [15:0] RST_STORED_THRESHOLD = 16'h1234;

	localparam logic [3:0] MAX_FRAME_BYTES = 4'd8;

	localparam logic [7:0] SVC_RESET = 8'h11;
	localparam logic [7:0] SVC_WRITE = 8'h2E;
	localparam logic [7:0] SVC_READ  = 8'h22;

	localparam logic [7:0] POS_RESET = 8'h51;
	localparam logic [7:0] POS_WRITE = 8'h6E;
	localparam logic [7:0] POS_READ  = 8'h62;
	localparam logic [7:0] NEG_MARK  = 8'h7F;

	localparam logic [7:0] NRC_SNS     = 8'h11;
	localparam logic [7:0] NRC_SFNS    = 8'h12;
	localparam logic [7:0] NRC_LEN     = 8'h13;
	localparam logic [7:0] NRC_TOOLONG = 8'h14;
	localparam logic [7:0] NRC_ROOR    = 8'h31;
	localparam logic [7:0] NRC_SAD     = 8'h33;

	localparam logic [7:0] SUB_HARD_RESET = 8'h01;
	localparam logic [7:0] SUB_ID_MASK    = 8'h7F;

	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} udr_cmd_t;

	typedef struct packed {
		logic scan_last;
	} udr_sts_t;

endpackage

// File: hdl/udr_ctrl.sv
// Controller state machine of the diagnostic responder.
// Depends on udr_pkg for the command and status types.
module udr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output udr_pkg::udr_cmd_t cmd,
	input  udr_pkg::udr_sts_t sts
);
	import udr_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/udr_datapath.sv
// Datapath of the diagnostic responder: configuration registers, request
// capture, identifier scan, stored threshold and the response register.
// Depends on udr_pkg.
module udr_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [udr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [udr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [3:0]                       req_len,
	input  logic [7:1][7:0]                  req_bytes,
	input  logic [15:0]                      adc,
	input  udr_pkg::udr_cmd_t                cmd,
	output udr_pkg::udr_sts_t                sts,
	output logic                             rsp_send,
	output logic                             rsp_reset,
	output logic [10:0]                      rsp_id,
	output logic [3:0]                       rsp_len,
	output logic [7:0][7:0]                  rsp_bytes
);
	import udr_pkg::*;

	logic [7:0]  security_level_q;
	logic [7:0]  required_level_q;
	logic [15:0] engine_temp_id_q;
	logic [15:0] threshold_id_q;
	logic [10:0] response_can_id_q;
	logic [15:0] stored_threshold_q;

	logic [3:0]      len_q;
	logic [7:1][7:0] b_q;
	logic [15:0]     adc_q;
	logic [1:0]      pair_q;
	logic            found_q;
	logic            toolong_q;
	logic [7:0]      hit_hi_q;
	logic [7:0]      hit_lo_q;
	logic [15:0]     hit_val_q;

	logic [3:0]  pair_start;
	logic [3:0]  next_start;
	logic [7:0]  did_hi;
	logic [7:0]  did_lo;
	logic [15:0] did;
	logic        is_temp;
	logic        is_match;

	logic            n_send;
	logic            n_reset;
	logic [3:0]      n_len;
	logic [7:0][7:0] n_bytes;
	logic            store_en;
	logic [7:0]      sid;
	logic [15:0]     wr_did;
	logic [15:0]     wr_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			security_level_q  <= RST_SECURITY_LEVEL;
			required_level_q  <= RST_REQUIRED_LEVEL;
			engine_temp_id_q  <= RST_ENGINE_TEMP_ID;
			threshold_id_q    <= RST_THRESHOLD_ID;
			response_can_id_q <= RST_RESPONSE_CAN_ID;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SECURITY_LEVEL:  security_level_q  <= cfg_data[7:0];
				REG_REQUIRED_LEVEL:  required_level_q  <= cfg_data[7:0];
				REG_ENGINE_TEMP_ID:  engine_temp_id_q  <= cfg_data;
				REG_THRESHOLD_ID:    threshold_id_q    <= cfg_data;
				REG_RESPONSE_CAN_ID: response_can_id_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	assign pair_start = {1'b0, pair_q, 1'b0} + 4'd2;
	assign next_start = {1'b0, pair_q, 1'b0} + 4'd4;
	assign sts.scan_last = (pair_q == 2'd2) || (next_start >= len_q);

	always_comb begin
		case (pair_q)
			2'd0: begin
				did_hi = b_q[2];
				did_lo = b_q[3];
			end
			2'd1: begin
				did_hi = b_q[4];
				did_lo = b_q[5];
			end
			default: begin
				did_hi = b_q[6];
				did_lo = b_q[7];
			end
		endcase
	end

	assign did      = {did_hi, did_lo};
	assign is_temp  = (did == engine_temp_id_q);
	assign is_match = (pair_start < len_q) && !toolong_q &&
		(is_temp || did == threshold_id_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q    <= 2'd0;
			found_q   <= 1'b0;
			toolong_q <= 1'b0;
		end else if (cmd.load) begin
			pair_q    <= 2'd0;
			found_q   <= 1'b0;
			toolong_q <= 1'b0;
		end else if (cmd.scan) begin
			pair_q <= pair_q + 2'd1;
			if (is_match) begin
				if (found_q) begin
					toolong_q <= 1'b1;
				end else begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			len_q <= req_len;
			b_q   <= req_bytes;
			adc_q <= adc;
		end
		if (cmd.scan && is_match && !found_q) begin
			hit_hi_q  <= did_hi;
			hit_lo_q  <= did_lo;
			hit_val_q <= is_temp ? adc_q : stored_threshold_q;
		end
	end

	assign sid    = b_q[1];
	assign wr_did = {b_q[2], b_q[3]};
	assign wr_val = {b_q[4], b_q[5]};

	always_comb begin
		n_send   = 1'b1;
		n_reset  = 1'b0;
		n_len    = 4'd0;
		n_bytes  = '0;
		store_en = 1'b0;
		// Negative answer by default; positive paths overwrite it.
		n_bytes[0] = 8'h03;
		n_bytes[1] = NEG_MARK;
		n_bytes[2] = sid;
		n_bytes[3] = NRC_SNS;
		n_len      = 4'd4;
		case (sid)
			SVC_RESET: begin
				if (len_q < 4'd3 || len_q > MAX_FRAME_BYTES) begin
					n_bytes[3] = NRC_LEN;
				end else if ((b_q[2] & SUB_ID_MASK) != SUB_HARD_RESET) begin
					n_bytes[3] = NRC_SFNS;
				end else if (security_level_q < required_level_q) begin
					n_bytes[3] = NRC_SAD;
				end else begin
					n_reset = 1'b1;
					n_bytes = '0;
					if (b_q[2][7]) begin
						n_send = 1'b0;
						n_len  = 4'd0;
					end else begin
						n_len      = 4'd3;
						n_bytes[0] = 8'h02;
						n_bytes[1] = POS_RESET;
						n_bytes[2] = b_q[2];
					end
				end
			end
			SVC_WRITE: begin
				if (len_q < 4'd5) begin
					n_bytes[3] = NRC_LEN;
				end else if (wr_did != threshold_id_q) begin
					n_bytes[3] = NRC_ROOR;
				end else if (len_q >= 4'd7) begin
					n_bytes[3] = NRC_LEN;
				end else if (wr_val[15:12] != 4'd0) begin
					n_bytes[3] = NRC_ROOR;
				end else begin
					store_en   = 1'b1;
					n_bytes[1] = POS_WRITE;
					n_bytes[2] = b_q[2];
					n_bytes[3] = b_q[3];
				end
			end
			SVC_READ: begin
				if (len_q < 4'd4 || len_q[0] || len_q > MAX_FRAME_BYTES) begin
					n_bytes[3] = NRC_LEN;
				end else if (toolong_q) begin
					n_bytes[3] = NRC_TOOLONG;
				end else if (!found_q) begin
					n_bytes[3] = NRC_ROOR;
				end else begin
					n_len      = 4'd6;
					n_bytes[0] = 8'h05;
					n_bytes[1] = POS_READ;
					n_bytes[2] = hit_hi_q;
					n_bytes[3] = hit_lo_q;
					n_bytes[4] = hit_val_q[15:8];
					n_bytes[5] = hit_val_q[7:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_threshold_q <= RST_STORED_THRESHOLD;
		end else if (cmd.finish && store_en) begin
			stored_threshold_q <= wr_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_send  <= n_send;
			rsp_reset <= n_reset;
			rsp_id    <= response_can_id_q;
			rsp_len   <= n_len;
			rsp_bytes <= n_bytes;
		end
	end

endmodule

// File: hdl/uds_diagnostic_responder.sv
// Single-frame diagnostic responder, top level: udr_ctrl and udr_datapath.
// After acceptance the identifier scan visits one byte pair per cycle (one to three pairs);
// the finish state then registers the result once the output slot is free.
// A new item is taken only in the idle state, once the last result is registered; a waiting
// result does not block acceptance, but holds the following item until it is taken.
// Reset restores the configuration registers and the stored threshold. Depends on udr_pkg.
module uds_diagnostic_responder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [3:0]                     request_length,
	input  logic [7:0]                     request_byte_0,
	input  logic [7:0]                     request_byte_1,
	input  logic [7:0]                     request_byte_2,
	input  logic [7:0]                     request_byte_3,
	input  logic [7:0]                     request_byte_4,
	input  logic [7:0]                     request_byte_5,
	input  logic [7:0]                     request_byte_6,
	input  logic [7:0]                     request_byte_7,
	input  logic [15:0]                    adc_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           send_frame,
	output logic                           reset_request,
	output logic [10:0]                    frame_id,
	output logic [3:0]                     response_length,
	output logic [7:0]                     response_byte_0,
	output logic [7:0]                     response_byte_1,
	output logic [7:0]                     response_byte_2,
	output logic [7:0]                     response_byte_3,
	output logic [7:0]                     response_byte_4,
	output logic [7:0]                     response_byte_5,
	output logic [7:0]                     response_byte_6,
	output logic [7:0]                     response_byte_7,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [udr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [udr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import udr_pkg::*;

	udr_cmd_t        cmd;
	udr_sts_t        sts;
	logic [7:1][7:0] req_bytes;
	logic [7:0][7:0] rsp_bytes;

	// The protocol control byte is not examined.
	assign req_bytes = {request_byte_7, request_byte_6, request_byte_5, request_byte_4,
		request_byte_3, request_byte_2, request_byte_1};
	assign cfg_ready = 1'b1;

	assign response_byte_0 = rsp_bytes[0];
	assign response_byte_1 = rsp_bytes[1];
	assign response_byte_2 = rsp_bytes[2];
	assign response_byte_3 = rsp_bytes[3];
	assign response_byte_4 = rsp_bytes[4];
	assign response_byte_5 = rsp_bytes[5];
	assign response_byte_6 = rsp_bytes[6];
	assign response_byte_7 = rsp_bytes[7];

	udr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	udr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_len   (request_length),
		.req_bytes (req_bytes),
		.adc       (adc_value),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_send  (send_frame),
		.rsp_reset (reset_request),
		.rsp_id    (frame_id),
		.rsp_len   (response_length),
		.rsp_bytes (rsp_bytes)
	);

endmodule
